// File: sv/escaped_rle_bitmap_run_decoder_defines.svh
// assertion helpers for the run decoder
`ifndef ESCAPED_RLE_BITMAP_RUN_DECODER_DEFINES_SVH
`define ESCAPED_RLE_BITMAP_RUN_DECODER_DEFINES_SVH

// same-cycle implication, checked on clk with rst as disable
`define ERBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ERBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/erbd_pkg.sv
package erbd_pkg;

  localparam int FRAME_WIDTH   = 128;
  localparam int FRAME_HEIGHT  = 64;
  localparam int BYTES_PER_ROW = (FRAME_WIDTH / 8 > 0) ? FRAME_WIDTH / 8 : 1;

  localparam int COL_W = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam int COUNT_W       = 15;
  localparam int FRAME_CNT_W   = 32;
  localparam int FRAMES_OUT_W  = 6;
  localparam int COLUMN_OUT_W  = 4;
  localparam int ROW_OUT_W     = 6;

  // reciprocal divide of a COUNT_W bit value by a small constant
  localparam int RECIP_SHIFT = COUNT_W;
  localparam int RECIP_W     = COUNT_W + 1;
  localparam int PROD_W      = COUNT_W + RECIP_W;
  localparam int RECIP_COL   = (2 ** RECIP_SHIFT) / BYTES_PER_ROW;
  localparam int RECIP_ROW   = (2 ** RECIP_SHIFT) / FRAME_HEIGHT;

  localparam logic [COL_W:0] COL_LIMIT = (COL_W + 1)'(BYTES_PER_ROW);
  localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(FRAME_HEIGHT);

  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ESC_ZERO_CODE = 8'h55;
  localparam logic [7:0] ESC_ONE_CODE  = 8'hAA;
  localparam logic [7:0] RUN_ZERO_PAT  = 8'h00;
  localparam logic [7:0] RUN_ONE_PAT   = 8'hFF;
  localparam int         LONG_FLAG_BIT = 7;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_ZERO_RUN,
    ESC_ONE_RUN
  } erbd_esc_t;

  // one decoded run, count already split into whole frames, rows and columns
  typedef struct packed {
    logic [7:0]         pattern;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] frames;
    logic [ROW_W-1:0]   rows;
    logic [COL_W-1:0]   cols;
  } erbd_desc_t;

endpackage

// File: sv/erbd_front.sv
module erbd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    stream_byte,
  input  logic [erbd_pkg::QUEUE_AW:0]   q_used,
  output logic                          q_push,
  output erbd_pkg::erbd_desc_t          q_data
);

  localparam int CW = erbd_pkg::COUNT_W;
  localparam int PW = erbd_pkg::PROD_W;
  localparam int TW = erbd_pkg::QUEUE_AW + 2;

  erbd_pkg::erbd_esc_t esc_kind, esc_kind_next;
  logic       pending, pending_next;
  logic [6:0] low_part, low_part_next;

  logic          accept;
  logic          emit;
  logic [7:0]    emit_pat;
  logic [CW-1:0] emit_cnt;
  logic [CW-1:0] long_cnt;
  logic [7:0]    run_pat;

  logic          a_valid, b_valid, c_valid, d_valid;
  logic [7:0]    a_pat, b_pat, c_pat, d_pat;
  logic [CW-1:0] a_count, b_count, c_count, d_count;
  logic [PW-1:0] b_prod, d_prod;
  logic [CW-1:0] c_q1, d_q1;
  logic [erbd_pkg::COL_W-1:0] c_col, d_col;

  logic [CW-1:0] q0, prod_back0, rem0, q1_next;
  logic [erbd_pkg::COL_W-1:0] col_next;
  logic [CW-1:0] q2, prod_back2, rem2, frames_val;
  logic [erbd_pkg::ROW_W-1:0] rows_val;
  logic [TW-1:0] inflight;

  // credit: every descriptor in the front pipeline already owns a queue slot
  assign inflight = TW'(q_used) + TW'(a_valid) + TW'(b_valid) + TW'(c_valid) + TW'(d_valid);
  assign in_stall = (inflight >= TW'(erbd_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  assign long_cnt = {stream_byte, low_part};
  assign run_pat  = (esc_kind == erbd_pkg::ESC_ZERO_RUN) ? erbd_pkg::RUN_ZERO_PAT
                                                         : erbd_pkg::RUN_ONE_PAT;

  always_comb begin
    esc_kind_next = esc_kind;
    pending_next  = pending;
    low_part_next = low_part;
    if (accept) begin
      unique case (esc_kind)
        erbd_pkg::ESC_NONE: begin
          if (stream_byte == erbd_pkg::ESC_ZERO_CODE) begin
            esc_kind_next = erbd_pkg::ESC_ZERO_RUN;
          end else if (stream_byte == erbd_pkg::ESC_ONE_CODE) begin
            esc_kind_next = erbd_pkg::ESC_ONE_RUN;
          end
        end
        default: begin
          if (pending) begin
            esc_kind_next = erbd_pkg::ESC_NONE;
            pending_next  = 1'b0;
            low_part_next = 7'd0;
          end else if (!stream_byte[erbd_pkg::LONG_FLAG_BIT]) begin
            esc_kind_next = erbd_pkg::ESC_NONE;
          end else begin
            low_part_next = stream_byte[6:0];
            pending_next  = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    emit     = 1'b0;
    emit_pat = stream_byte;
    emit_cnt = CW'(1);
    unique case (esc_kind)
      erbd_pkg::ESC_NONE: begin
        emit = accept && (stream_byte != erbd_pkg::ESC_ZERO_CODE)
                      && (stream_byte != erbd_pkg::ESC_ONE_CODE);
      end
      default: begin
        if (pending) begin
          emit_pat = run_pat;
          emit_cnt = long_cnt;
          emit     = accept && (long_cnt != '0);
        end else if (stream_byte == 8'd0) begin
          // escaped escape byte
          emit_pat = (esc_kind == erbd_pkg::ESC_ZERO_RUN) ? erbd_pkg::ESC_ZERO_CODE
                                                          : erbd_pkg::ESC_ONE_CODE;
          emit     = accept;
        end else if (!stream_byte[erbd_pkg::LONG_FLAG_BIT]) begin
          emit_pat = run_pat;
          emit_cnt = CW'(stream_byte);
          emit     = accept;
        end
      end
    endcase
  end

  // count / bytes_per_row: estimate, then one correction step
  assign q0         = b_prod[erbd_pkg::RECIP_SHIFT +: CW];
  assign prod_back0 = CW'(q0 * CW'(erbd_pkg::BYTES_PER_ROW));
  assign rem0       = b_count - prod_back0;
  always_comb begin
    if (rem0 >= CW'(erbd_pkg::BYTES_PER_ROW)) begin
      q1_next  = q0 + CW'(1);
      col_next = erbd_pkg::COL_W'(rem0 - CW'(erbd_pkg::BYTES_PER_ROW));
    end else begin
      q1_next  = q0;
      col_next = erbd_pkg::COL_W'(rem0);
    end
  end

  // row quotient / frame_height, same scheme
  assign q2         = d_prod[erbd_pkg::RECIP_SHIFT +: CW];
  assign prod_back2 = CW'(q2 * CW'(erbd_pkg::FRAME_HEIGHT));
  assign rem2       = d_q1 - prod_back2;
  always_comb begin
    if (rem2 >= CW'(erbd_pkg::FRAME_HEIGHT)) begin
      frames_val = q2 + CW'(1);
      rows_val   = erbd_pkg::ROW_W'(rem2 - CW'(erbd_pkg::FRAME_HEIGHT));
    end else begin
      frames_val = q2;
      rows_val   = erbd_pkg::ROW_W'(rem2);
    end
  end

  assign q_push         = d_valid;
  assign q_data.pattern = d_pat;
  assign q_data.count   = d_count;
  assign q_data.frames  = frames_val;
  assign q_data.rows    = rows_val;
  assign q_data.cols    = d_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_kind <= erbd_pkg::ESC_NONE;
      pending  <= 1'b0;
      low_part <= 7'd0;
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d_valid  <= 1'b0;
    end else begin
      esc_kind <= esc_kind_next;
      pending  <= pending_next;
      low_part <= low_part_next;
      a_valid  <= emit;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d_valid  <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_pat   <= emit_pat;
    a_count <= emit_cnt;
    b_pat   <= a_pat;
    b_count <= a_count;
    b_prod  <= PW'(a_count) * PW'(erbd_pkg::RECIP_COL);
    c_pat   <= b_pat;
    c_count <= b_count;
    c_q1    <= q1_next;
    c_col   <= col_next;
    d_pat   <= c_pat;
    d_count <= c_count;
    d_q1    <= c_q1;
    d_col   <= c_col;
    d_prod  <= PW'(c_q1) * PW'(erbd_pkg::RECIP_ROW);
  end

endmodule

// File: sv/erbd_queue.sv
module erbd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  erbd_pkg::erbd_desc_t        push_data,
  input  logic                        pop,
  output erbd_pkg::erbd_desc_t        head,
  output logic                        head_valid,
  output logic [erbd_pkg::QUEUE_AW:0] used
);

  localparam int AW = erbd_pkg::QUEUE_AW;

  erbd_pkg::erbd_desc_t entries [erbd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign head       = entries[rd_ptr];
  assign head_valid = (used != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      used <= used + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

endmodule

// File: sv/erbd_back.sv
module erbd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  erbd_pkg::erbd_desc_t head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           pattern_byte,
  output logic [14:0]          byte_count,
  output logic [3:0]           start_column,
  output logic [5:0]           start_row,
  output logic [31:0]          start_frame,
  output logic [5:0]           frames_completed
);

  localparam int CLW = erbd_pkg::COL_W;
  localparam int RW  = erbd_pkg::ROW_W;
  localparam int CW  = erbd_pkg::COUNT_W;

  logic [CLW-1:0] col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [erbd_pkg::FRAME_CNT_W-1:0] frame_counter, frame_counter_next;

  logic [CLW:0]  col_sum;
  logic [RW:0]   row_sum;
  logic          col_wrap, frame_wrap;
  logic [CW:0]   frames;

  assign pop = head_valid && (!out_valid || !out_stall);

  // column then row carry, both stay below twice their limit
  assign col_sum  = (CLW + 1)'(col) + (CLW + 1)'(head.cols);
  assign col_wrap = (col_sum >= erbd_pkg::COL_LIMIT);
  assign row_sum  = (RW + 1)'(row) + (RW + 1)'(head.rows) + (RW + 1)'(col_wrap);
  assign frame_wrap = (row_sum >= erbd_pkg::ROW_LIMIT);
  assign frames   = (CW + 1)'(head.frames) + (CW + 1)'(frame_wrap);

  always_comb begin
    col_next           = col;
    row_next           = row;
    frame_counter_next = frame_counter;
    if (pop) begin
      col_next = col_wrap ? CLW'(col_sum - erbd_pkg::COL_LIMIT) : CLW'(col_sum);
      row_next = frame_wrap ? RW'(row_sum - erbd_pkg::ROW_LIMIT) : RW'(row_sum);
      frame_counter_next = frame_counter + erbd_pkg::FRAME_CNT_W'(frames);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col           <= '0;
      row           <= '0;
      frame_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      col           <= col_next;
      row           <= row_next;
      frame_counter <= frame_counter_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pattern_byte     <= head.pattern;
      byte_count       <= head.count;
      start_column     <= erbd_pkg::COLUMN_OUT_W'(col);
      start_row        <= erbd_pkg::ROW_OUT_W'(row);
      start_frame      <= frame_counter;
      frames_completed <= erbd_pkg::FRAMES_OUT_W'(frames);
    end
  end

endmodule

// File: sv/escaped_rle_bitmap_run_decoder.sv
// path: a byte that closes a literal or run is registered through front stages a, b,
//   c and d, the descriptor queue and the output register before out_valid shows it
// throughput: one stream byte per cycle while in_stall is low, kept up by the
//   row/column/frame carry update in the back end
// reset (rst, synchronous): escape state, position and frame counter clear, queue empties
`include "escaped_rle_bitmap_run_decoder_defines.svh"

module escaped_rle_bitmap_run_decoder (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  // run descriptors
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pattern_byte,
  output logic [14:0] byte_count,
  output logic [3:0]  start_column,
  output logic [5:0]  start_row,
  output logic [31:0] start_frame,
  output logic [5:0]  frames_completed
);

  // front end: escape parsing plus a constant-divisor pipeline that splits
  // each count into whole frames, rows and leftover columns
  // back end: adds that split to the current position with two carries
  // a short queue sits between them; the front only takes a byte when a
  // queue slot is free for everything already in its pipeline

  // fill level of a full descriptor queue
  localparam logic [erbd_pkg::QUEUE_AW:0] QUEUE_FULL =
    (erbd_pkg::QUEUE_AW + 1)'(erbd_pkg::QUEUE_DEPTH);

  logic                        q_push;
  erbd_pkg::erbd_desc_t        q_data;
  logic                        q_pop;
  erbd_pkg::erbd_desc_t        q_head;
  logic                        q_head_valid;
  logic [erbd_pkg::QUEUE_AW:0] q_used;

  erbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .q_used      (q_used),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  // descriptor queue between the two halves
  erbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .used       (q_used)
  );

  // position tracking and the output register
  erbd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (q_head),
    .head_valid       (q_head_valid),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pattern_byte     (pattern_byte),
    .byte_count       (byte_count),
    .start_column     (start_column),
    .start_row        (start_row),
    .start_frame      (start_frame),
    .frames_completed (frames_completed)
  );

  // the credit scheme must never push into a full queue
  `ERBD_ASSERT_NOW(a_no_overflow, q_push, q_used < QUEUE_FULL, "descriptor queue overflow")
  // zero-length runs are dropped in the front end
  `ERBD_ASSERT_NOW(a_count_nonzero, out_valid, byte_count != 15'd0, "zero count descriptor")
  // a taken result with nothing queued leaves the output empty
  `ERBD_ASSERT_NEXT(a_drain, out_valid && !out_stall && !q_head_valid, !out_valid, "stale descriptor repeated")

endmodule
